FILE: rtl/assert_macros.svh
// Assertion macros for the RTL files; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/sprc_pkg.sv
// Types, constants and helpers for the sprite rotate and recolor block.
package sprc_pkg;

	localparam int COORD_W     = 9;
	localparam int COLOR_W     = 24;
	localparam int TRIG_W      = 16;
	localparam int DIM_W       = 7;
	localparam int DITHER_W    = 25;
	localparam int PROD_W      = COORD_W + TRIG_W;
	localparam int SUM_W       = PROD_W + 1;
	localparam int FRAC_BITS   = 14;
	localparam int SRC_W       = SUM_W - FRAC_BITS;
	localparam int CMP_W       = SRC_W + 1;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 25;
	localparam int ADDR_MAX_W  = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int DEF_MAX_W   = 64;
	localparam int DEF_MAX_H   = 64;

	localparam logic [SUM_W-1:0]    FRAC_MASK  = SUM_W'((1 << FRAC_BITS) - 1);
	localparam logic [DITHER_W-1:0] DITHER_OFF = '1;

	typedef enum logic {
		CMD_LOAD   = 1'b0,
		CMD_RENDER = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COS,
		REG_SIN,
		REG_WIDTH,
		REG_HEIGHT,
		REG_TRANSP,
		REG_SPRITE,
		REG_SPRITE_TWO,
		REG_DARK
	} cfg_reg_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] cos_q;
		logic signed [TRIG_W-1:0] sin_q;
		logic [DIM_W-1:0]         src_width;
		logic [DIM_W-1:0]         src_height;
		logic [COLOR_W-1:0]       transparent_color;
		logic [COLOR_W-1:0]       fill_color;
		logic [DITHER_W-1:0]      fill_color_two;
		logic [COLOR_W-1:0]       dark_black;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		cos_q:             16'sd16384,
		sin_q:             16'sd0,
		src_width:         7'd64,
		src_height:        7'd64,
		transparent_color: 24'd0,
		fill_color:        24'd0,
		fill_color_two:    DITHER_OFF,
		dark_black:        24'd1
	};

	typedef struct packed {
		cmd_t                      cmd;
		logic                      hit;
		logic [ADDR_MAX_W-1:0]     addr;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [COLOR_W-1:0]        color;
	} queue_item_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              full;
		logic              empty;
	} queue_stat_t;

	// Divide by 2^FRAC_BITS, rounding toward zero.
	function automatic logic signed [SRC_W-1:0] trunc_frac(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] b;
		b = v + (v[SUM_W-1] ? FRAC_MASK : '0);
		return SRC_W'(b >>> FRAC_BITS);
	endfunction

endpackage

FILE: rtl/sprc_front.sv
// Front end: accepts items, maps render coordinates to the source and classifies them.
module sprc_front #(
	parameter int MAX_SRC_WIDTH  = sprc_pkg::DEF_MAX_W,
	parameter int MAX_SRC_HEIGHT = sprc_pkg::DEF_MAX_H
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  sprc_pkg::cfg_t                          cfg,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic                                    command,
	input  logic signed [sprc_pkg::COORD_W-1:0]     coord_x,
	input  logic signed [sprc_pkg::COORD_W-1:0]     coord_y,
	input  logic [sprc_pkg::COLOR_W-1:0]            pixel_color,
	output logic                                    push_valid,
	input  logic                                    push_ready,
	output sprc_pkg::queue_item_t                   push_item
);
	import sprc_pkg::*;

	localparam int CW = $clog2(MAX_SRC_WIDTH);
	localparam int RW = $clog2(MAX_SRC_HEIGHT);
	localparam int AW = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT);
	localparam logic signed [CMP_W-1:0] WMAX = CMP_W'(MAX_SRC_WIDTH);
	localparam logic signed [CMP_W-1:0] HMAX = CMP_W'(MAX_SRC_HEIGHT);
	localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_SRC_WIDTH);

	logic adv1, adv2, adv3;
	logic v_s1, v_s2, v_s3;

	cmd_t                      cmd_s1, cmd_s2;
	logic signed [COORD_W-1:0] x_s1, y_s1, x_s2, y_s2;
	logic [COLOR_W-1:0]        pix_s1, pix_s2;
	logic signed [PROD_W-1:0]  xc_s1, ys_s1, yc_s1, xs_s1;
	logic signed [PROD_W-1:0]  xc_d, ys_d, yc_d, xs_d;
	logic signed [SRC_W-1:0]   sx_s2, sy_s2;
	queue_item_t               item_s3, item_d;

	logic signed [CMP_W-1:0] w_lim, h_lim, w_cfg, h_cfg, sx_e, sy_e, x_e, y_e;
	logic [CMP_W-1:0]        row_r;
	logic [RW-1:0]           row_sel;
	logic [CW-1:0]           col_sel;
	logic                    rd_hit, ld_hit;

	assign adv3     = !v_s3 || push_ready;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	assign xc_d = coord_x * cfg.cos_q;
	assign ys_d = coord_y * cfg.sin_q;
	assign yc_d = coord_y * cfg.cos_q;
	assign xs_d = coord_x * cfg.sin_q;

	always_comb begin
		w_cfg   = $signed(CMP_W'(cfg.src_width));
		h_cfg   = $signed(CMP_W'(cfg.src_height));
		w_lim   = (w_cfg > WMAX) ? WMAX : w_cfg;
		h_lim   = (h_cfg > HMAX) ? HMAX : h_cfg;
		sx_e    = CMP_W'(sx_s2);
		sy_e    = CMP_W'(sy_s2);
		x_e     = CMP_W'(x_s2);
		y_e     = CMP_W'(y_s2);
		rd_hit  = (sx_e >= 0) && (sx_e < w_lim) && (sy_e >= 0) && (sy_e < h_lim);
		ld_hit  = (x_e >= 0) && (x_e < WMAX) && (y_e >= 0) && (y_e < HMAX);
		row_r   = h_lim - CMP_W'(1) - sy_e;
		if (cmd_s2 == CMD_LOAD) begin
			row_sel = y_s2[RW-1:0];
			col_sel = x_s2[CW-1:0];
		end else begin
			row_sel = row_r[RW-1:0];
			col_sel = sx_s2[CW-1:0];
		end
		item_d.cmd   = cmd_s2;
		item_d.hit   = (cmd_s2 == CMD_LOAD) ? ld_hit : rd_hit;
		item_d.addr  = ADDR_MAX_W'(AW'(row_sel) * ROW_STRIDE + AW'(col_sel));
		item_d.x     = x_s2;
		item_d.y     = y_s2;
		item_d.color = pix_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= in_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			cmd_s1 <= cmd_t'(command);
			x_s1   <= coord_x;
			y_s1   <= coord_y;
			pix_s1 <= pixel_color;
			xc_s1  <= xc_d;
			ys_s1  <= ys_d;
			yc_s1  <= yc_d;
			xs_s1  <= xs_d;
		end
		if (adv2) begin
			cmd_s2 <= cmd_s1;
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			pix_s2 <= pix_s1;
			sx_s2  <= trunc_frac(SUM_W'(xc_s1) + SUM_W'(ys_s1));
			sy_s2  <= trunc_frac(SUM_W'(yc_s1) - SUM_W'(xs_s1));
		end
		if (adv3) begin
			item_s3 <= item_d;
		end
	end

	assign push_valid = v_s3;
	assign push_item  = item_s3;

endmodule

FILE: rtl/sprc_queue.sv
// Short queue between the front end and the back end.
module sprc_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push_valid,
	output logic                    push_ready,
	input  sprc_pkg::queue_item_t   push_item,
	output logic                    pop_valid,
	input  logic                    pop_ready,
	output sprc_pkg::queue_item_t   pop_item,
	output sprc_pkg::queue_stat_t   stat
);
	import sprc_pkg::*;

	queue_item_t       slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push, pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	assign stat.count = count_q;
	assign stat.full  = !push_ready;
	assign stat.empty = !pop_valid;

endmodule

FILE: rtl/sprc_back.sv
// Back end: pixel store, read, recolor and output register.
module sprc_back #(
	parameter int MAX_SRC_WIDTH  = sprc_pkg::DEF_MAX_W,
	parameter int MAX_SRC_HEIGHT = sprc_pkg::DEF_MAX_H
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sprc_pkg::cfg_t                      cfg,
	input  logic                                q_valid,
	output logic                                q_pop,
	input  sprc_pkg::queue_item_t               q_item,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [sprc_pkg::COORD_W-1:0] dest_x,
	output logic signed [sprc_pkg::COORD_W-1:0] dest_y,
	output logic [sprc_pkg::COLOR_W-1:0]        out_color,
	output logic                                write_enable
);
	import sprc_pkg::*;

	localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	logic [COLOR_W-1:0] store [DEPTH];

	logic                      adv4, adv5, pop;
	logic [AW-1:0]             addr;
	logic                      v_s4, v_s5;
	logic [COLOR_W-1:0]        rd_s4;
	logic                      hit_s4;
	logic signed [COORD_W-1:0] x_s4, y_s4;
	logic signed [COORD_W-1:0] x_s5, y_s5;
	logic [COLOR_W-1:0]        color_s5, rc;
	logic                      we_s5;

	assign adv5  = !v_s5 || out_ready;
	assign adv4  = !v_s4 || adv5;
	assign pop   = q_valid && adv4;
	assign q_pop = pop;
	assign addr  = q_item.addr[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv4) begin
				v_s4 <= pop && (q_item.cmd == CMD_RENDER);
			end
			if (adv5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && (q_item.cmd == CMD_LOAD) && q_item.hit) begin
			store[addr] <= q_item.color;
		end
		if (pop) begin
			rd_s4  <= store[addr];
			hit_s4 <= q_item.hit;
			x_s4   <= q_item.x;
			y_s4   <= q_item.y;
		end
	end

	always_comb begin
		if (rd_s4 == cfg.transparent_color) begin
			rc = '0;
		end else if (rd_s4 != '0) begin
			rc = rd_s4;
		end else if (cfg.fill_color == '0) begin
			rc = cfg.dark_black;
		end else if (cfg.fill_color_two == DITHER_OFF) begin
			rc = cfg.fill_color;
		end else if ((x_s4[0] ^ y_s4[0]) == 1'b0) begin
			rc = cfg.fill_color_two[COLOR_W-1:0];
		end else begin
			rc = cfg.fill_color;
		end
	end

	always_ff @(posedge clk) begin
		if (adv5) begin
			x_s5     <= x_s4;
			y_s5     <= y_s4;
			color_s5 <= hit_s4 ? rc : '0;
			we_s5    <= hit_s4;
		end
	end

	assign out_valid    = v_s5;
	assign dest_x       = x_s5;
	assign dest_y       = y_s5;
	assign out_color    = color_s5;
	assign write_enable = we_s5;

endmodule

FILE: rtl/sprite_rotate_recolor.sv
// Top level of the sprite rotate and recolor block.
//
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 cos, 1 sin,
// 2 width, 3 height, 4 transparent color, 5 sprite color, 6 dither color,
// 7 dark black) at the clock edge; write only while the block is idle.
// Input channel (in_valid/in_ready): command 0 loads pixel_color into the
// pixel store at (coord_x, coord_y); command 1 renders destination
// (coord_x, coord_y) and yields one result. Loads yield nothing.
// Output channel (out_valid/out_ready): dest_x, dest_y, out_color, write_enable.
// Path: a render item is registered in stages s1, s2, s3, the queue, s4 and s5.
// Throughput: one item per clock unless out_ready stalls the output; each popped
// item reads the pixel store, and a load that hits also writes it.
// Reset: configuration returns to defaults and all stages empty; pixel store
// contents are undefined until loaded.
// Stall: the output register holds its result; the queue and front stages
// keep filling until full, then in_ready drops.
`include "assert_macros.svh"

module sprite_rotate_recolor #(
	parameter int MAX_SRC_WIDTH  = sprc_pkg::DEF_MAX_W,
	parameter int MAX_SRC_HEIGHT = sprc_pkg::DEF_MAX_H
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [sprc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [sprc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  command,
	input  logic signed [sprc_pkg::COORD_W-1:0]   coord_x,
	input  logic signed [sprc_pkg::COORD_W-1:0]   coord_y,
	input  logic [sprc_pkg::COLOR_W-1:0]          pixel_color,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [sprc_pkg::COORD_W-1:0]   dest_x,
	output logic signed [sprc_pkg::COORD_W-1:0]   dest_y,
	output logic [sprc_pkg::COLOR_W-1:0]          out_color,
	output logic                                  write_enable
);
	import sprc_pkg::*;

	cfg_t        cfg_q;
	logic        q_push_valid, q_push_ready, q_valid, q_pop;
	queue_item_t q_push_item, q_item;
	queue_stat_t q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_COS:        cfg_q.cos_q             <= cfg_wdata[TRIG_W-1:0];
				REG_SIN:        cfg_q.sin_q             <= cfg_wdata[TRIG_W-1:0];
				REG_WIDTH:      cfg_q.src_width         <= cfg_wdata[DIM_W-1:0];
				REG_HEIGHT:     cfg_q.src_height        <= cfg_wdata[DIM_W-1:0];
				REG_TRANSP:     cfg_q.transparent_color <= cfg_wdata[COLOR_W-1:0];
				REG_SPRITE:     cfg_q.fill_color        <= cfg_wdata[COLOR_W-1:0];
				REG_SPRITE_TWO: cfg_q.fill_color_two    <= cfg_wdata[DITHER_W-1:0];
				REG_DARK:       cfg_q.dark_black        <= cfg_wdata[COLOR_W-1:0];
			endcase
		end
	end

	sprc_front #(
		.MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
		.MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.pixel_color (pixel_color),
		.push_valid  (q_push_valid),
		.push_ready  (q_push_ready),
		.push_item   (q_push_item)
	);

	sprc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_item  (q_push_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_pop),
		.pop_item   (q_item),
		.stat       (q_stat)
	);

	sprc_back #(
		.MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
		.MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_item       (q_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.dest_x       (dest_x),
		.dest_y       (dest_y),
		.out_color    (out_color),
		.write_enable (write_enable)
	);

	`ASSERT_IMPLIES(a_miss_is_black, clk, arst_n, out_valid && !write_enable, out_color == '0)
	`ASSERT_IMPLIES(a_pop_not_empty, clk, arst_n, q_pop, !q_stat.empty)
	`ASSERT_IMPLIES(a_push_not_full, clk, arst_n, q_push_valid && q_push_ready, !q_stat.full)
	`ASSERT_NEXT(a_push_fills, clk, arst_n, q_push_valid && q_push_ready && !q_pop, !q_stat.empty)

endmodule
